FILE: rtl/ultrasonic_echo_ranger_core_defines.svh
// assertion macros shared by the ranger checker
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ranger check failed");

// next-cycle implication, disabled while reset is low
`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ranger check failed");

`endif

FILE: rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

    // default width of the microsecond counters
    localparam int unsigned TIME_BITS_DEF = 16;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned RES_W      = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LOW_US    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_US    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ACTIVE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CM_PER_US_Q16 = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_PRE_LOW_US    = 8'd2;
    localparam logic [7:0]  RST_TRIGGER_US    = 8'd10;
    localparam logic [15:0] RST_TIMEOUT_US    = 16'd10000;
    localparam logic        RST_ECHO_ACTIVE   = 1'b1;
    localparam logic [15:0] RST_CM_PER_US_Q16 = 16'd1124;

    typedef struct packed {
        logic [7:0]  pre_low_us;
        logic [7:0]  trigger_us;
        logic [15:0] timeout_us;
        logic        echo_active_level;
        logic [15:0] cm_per_us_q16;
    } t_cfg;

    typedef struct packed {
        logic trigger_level;
        logic busy;
        logic done;
        logic timed_out;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/uer_in_if.sv
`default_nettype none

interface uer_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic echo_level;

    modport source (output valid, output operation, output echo_level, input ready);
    modport sink   (input valid, input operation, input echo_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/uer_out_if.sv
`default_nettype none

interface uer_out_if
    import uer_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             trigger_level;
    logic             busy_res;
    logic             done_res;
    logic             timed_out;
    logic [RES_W-1:0] pulse_us;
    logic [RES_W-1:0] distance_cm;

    modport source (
        output valid, output trigger_level, output busy_res, output done_res,
        output timed_out, output pulse_us, output distance_cm, input ready
    );
    modport sink (
        input valid, input trigger_level, input busy_res, input done_res,
        input timed_out, input pulse_us, input distance_cm, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/uer_cfg_if.sv
`default_nettype none

interface uer_cfg_if
    import uer_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/uer_scale.sv
`default_nettype none

module uer_scale
    import uer_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic [TIME_BITS-1:0] i_width,
    input  wire logic [15:0]          i_scale,
    output logic      [RES_W-1:0]     o_pulse,
    output logic      [RES_W-1:0]     o_dist
);

    localparam int unsigned PW = TIME_BITS + 16;
    localparam int unsigned WX = (TIME_BITS > RES_W) ? TIME_BITS : RES_W;

    logic [PW-1:0]        prod;
    logic [TIME_BITS-1:0] prod_hi;
    logic [WX-1:0]        width_x;
    logic [WX-1:0]        dist_x;
    logic [WX-1:0]        res_max;

    assign prod    = PW'(i_width) * PW'(i_scale);
    assign prod_hi = prod[PW-1:16];
    assign width_x = WX'(i_width);
    assign dist_x  = WX'(prod_hi);
    assign res_max = WX'({RES_W{1'b1}});

    // saturate both results to the output field width
    assign o_pulse = (width_x > res_max) ? {RES_W{1'b1}} : width_x[RES_W-1:0];
    assign o_dist  = (dist_x > res_max) ? {RES_W{1'b1}} : dist_x[RES_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/uer_fsm.sv
`default_nettype none

module uer_fsm
    import uer_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_op,
    input  wire logic             i_echo,
    input  wire t_cfg             i_cfg,
    output t_status               o_status,
    output logic      [RES_W-1:0] o_pulse,
    output logic      [RES_W-1:0] o_dist
);

    localparam int unsigned WX = (TIME_BITS > 16) ? TIME_BITS : 16;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRELOW  = 3'd1,
        PH_HIGH    = 3'd2,
        PH_WAIT    = 3'd3,
        PH_MEASURE = 3'd4
    } t_phase;

    t_phase               r_phase,      n_phase;
    logic [7:0]           r_cnt,        n_cnt;
    logic [TIME_BITS-1:0] r_elapsed,    n_elapsed;
    logic [TIME_BITS-1:0] r_width,      n_width;
    logic [RES_W-1:0]     r_last_pulse, n_last_pulse;
    logic [RES_W-1:0]     r_last_dist,  n_last_dist;
    logic                 r_done,       n_done;
    logic                 r_tout,       n_tout;

    logic                 active;
    logic [7:0]           cnt_inc;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [TIME_BITS-1:0] width_inc;
    logic                 expired;
    logic [RES_W-1:0]     sc_pulse;
    logic [RES_W-1:0]     sc_dist;

    uer_scale #(.TIME_BITS(TIME_BITS)) u_scale (
        .i_width (r_width),
        .i_scale (i_cfg.cm_per_us_q16),
        .o_pulse (sc_pulse),
        .o_dist  (sc_dist)
    );

    assign active      = (i_echo == i_cfg.echo_active_level);
    assign cnt_inc     = r_cnt + 8'd1;
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + TIME_BITS'(1);
    assign width_inc   = (&r_width) ? r_width : r_width + TIME_BITS'(1);
    // a saturated count counts as expired
    assign expired     = (WX'(elapsed_inc) >= WX'(i_cfg.timeout_us)) || (&elapsed_inc);

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_elapsed    = r_elapsed;
        n_width      = r_width;
        n_last_pulse = r_last_pulse;
        n_last_dist  = r_last_dist;
        n_done       = r_done;
        n_tout       = r_tout;
        if (i_step) begin
            n_done = 1'b0;
            n_tout = 1'b0;
            if (i_op) begin
                // start is dropped while a measurement runs
                if (r_phase == PH_IDLE) begin
                    n_cnt     = 8'd0;
                    n_elapsed = '0;
                    n_width   = '0;
                    n_phase   = (i_cfg.pre_low_us == 8'd0) ? PH_HIGH : PH_PRELOW;
                end
            end else begin
                unique case (r_phase)
                    PH_PRELOW: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= i_cfg.pre_low_us) begin
                            n_phase = PH_HIGH;
                            n_cnt   = 8'd0;
                        end
                    end
                    PH_HIGH: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= i_cfg.trigger_us) begin
                            n_phase   = PH_WAIT;
                            n_cnt     = 8'd0;
                            n_elapsed = '0;
                            n_width   = '0;
                        end
                    end
                    PH_WAIT: begin
                        n_elapsed = elapsed_inc;
                        if (active) begin
                            n_phase = PH_MEASURE;
                            n_width = TIME_BITS'(1);
                        end else if (expired) begin
                            n_done       = 1'b1;
                            n_tout       = 1'b1;
                            n_last_pulse = '0;
                            n_last_dist  = '0;
                            n_phase      = PH_IDLE;
                            n_cnt        = 8'd0;
                        end
                    end
                    PH_MEASURE: begin
                        n_elapsed = elapsed_inc;
                        if (!active) begin
                            // echo ended, width is the count so far
                            n_done       = 1'b1;
                            n_last_pulse = sc_pulse;
                            n_last_dist  = sc_dist;
                            n_phase      = PH_IDLE;
                            n_cnt        = 8'd0;
                        end else begin
                            n_width = width_inc;
                            if (expired) begin
                                n_done       = 1'b1;
                                n_tout       = 1'b1;
                                n_last_pulse = '0;
                                n_last_dist  = '0;
                                n_phase      = PH_IDLE;
                                n_cnt        = 8'd0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cnt        <= 8'd0;
            r_elapsed    <= '0;
            r_width      <= '0;
            r_last_pulse <= '0;
            r_last_dist  <= '0;
            r_done       <= 1'b0;
            r_tout       <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_elapsed    <= n_elapsed;
            r_width      <= n_width;
            r_last_pulse <= n_last_pulse;
            r_last_dist  <= n_last_dist;
            r_done       <= n_done;
            r_tout       <= n_tout;
        end
    end

    assign o_status.trigger_level = (r_phase == PH_HIGH);
    assign o_status.busy          = (r_phase != PH_IDLE);
    assign o_status.done          = r_done;
    assign o_status.timed_out     = r_tout;
    assign o_pulse                = r_last_pulse;
    assign o_dist                 = r_last_dist;

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_echo_ranger_core.sv
`default_nettype none

// ultrasonic ranger controller: each input transaction is either a start request or a
// one-microsecond tick carrying the sampled echo level, and each one yields exactly one
// result transaction showing the trigger level to drive, busy, done, timeout and the
// width and distance of the last finished measurement. one transaction is taken every
// cycle unless the result stage is stalled; an item passes the input register, then the
// phase state and result registers, and the rate is set by the phase state loop, which
// updates once per item. the distance is (width * cm_per_us_q16) >> 16, truncated and
// saturated to 16 bits; a timeout reports width and distance 0. configuration writes
// are always accepted and should only be made while no result is outstanding.

module ultrasonic_echo_ranger_core
    import uer_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    uer_in_if.sink     i_in,
    uer_cfg_if.sink    i_cfg,
    uer_out_if.source  o_out
);

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic r_in_valid;
    logic r_in_op;
    logic r_in_echo;

    // result register valid, payload lives in the phase state machine
    logic r_out_valid;

    logic    advance;
    logic    step;
    t_status status;

    // result slot free or being drained this cycle
    assign advance = !r_out_valid || o_out.ready;
    // registered item is processed only when its result has a place to go
    assign step    = r_in_valid && advance;

    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_low_us        <= RST_PRE_LOW_US;
            r_cfg.trigger_us        <= RST_TRIGGER_US;
            r_cfg.timeout_us        <= RST_TIMEOUT_US;
            r_cfg.echo_active_level <= RST_ECHO_ACTIVE;
            r_cfg.cm_per_us_q16     <= RST_CM_PER_US_Q16;
        end else if (i_cfg.valid) begin
            // writes past the register list fall through
            unique case (i_cfg.index)
                CFG_PRE_LOW_US:    r_cfg.pre_low_us        <= i_cfg.data[7:0];
                CFG_TRIGGER_US:    r_cfg.trigger_us        <= i_cfg.data[7:0];
                CFG_TIMEOUT_US:    r_cfg.timeout_us        <= i_cfg.data;
                CFG_ECHO_ACTIVE:   r_cfg.echo_active_level <= i_cfg.data[0];
                CFG_CM_PER_US_Q16: r_cfg.cm_per_us_q16     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.operation;
            r_in_echo <= i_in.echo_level;
        end
    end

    // result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // phase sequencing, counters and scaling; its registers form the result payload
    uer_fsm #(.TIME_BITS(TIME_BITS)) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_op     (r_in_op),
        .i_echo   (r_in_echo),
        .i_cfg    (r_cfg),
        .o_status (status),
        .o_pulse  (o_out.pulse_us),
        .o_dist   (o_out.distance_cm)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.trigger_level = status.trigger_level;
    assign o_out.busy_res      = status.busy;
    assign o_out.done_res      = status.done;
    assign o_out.timed_out     = status.timed_out;

endmodule

`default_nettype wire

FILE: rtl/uer_chk.sv
`default_nettype none

`include "ultrasonic_echo_ranger_core_defines.svh"

module uer_chk
    import uer_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic             i_trigger,
    input wire logic             i_busy,
    input wire logic             i_done,
    input wire logic             i_tout,
    input wire logic [RES_W-1:0] i_pulse,
    input wire logic [RES_W-1:0] i_dist
);

    // a timeout is only ever reported on a finishing transaction
    `UER_ASSERT_IMP(a_tout_done, i_clk, i_rst_n, i_out_valid && i_tout, i_done)
    // timeout clears the reported width and distance
    `UER_ASSERT_IMP(a_tout_zero, i_clk, i_rst_n, i_out_valid && i_tout,
        (i_pulse == '0) && (i_dist == '0))
    // the trigger is raised only inside a measurement
    `UER_ASSERT_IMP(a_trig_busy, i_clk, i_rst_n, i_out_valid && i_trigger, i_busy)
    // a finished measurement returns to idle
    `UER_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, i_out_valid && i_done, !i_busy)
    // a stalled result holds
    `UER_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable({i_trigger, i_busy, i_done, i_tout, i_pulse, i_dist}))

endmodule

bind ultrasonic_echo_ranger_core uer_chk u_uer_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_trigger   (o_out.trigger_level),
    .i_busy      (o_out.busy_res),
    .i_done      (o_out.done_res),
    .i_tout      (o_out.timed_out),
    .i_pulse     (o_out.pulse_us),
    .i_dist      (o_out.distance_cm)
);

`default_nettype wire

FILE: tb/sv/ultrasonic_echo_ranger_core_tb.sv
`default_nettype none

module ultrasonic_echo_ranger_core_tb;
    import uer_pkg::*;

    // clock, reset and run control
    localparam int unsigned CLK_HALF        = 6;
    localparam int unsigned RESET_CYCLES    = 10;
    localparam int unsigned SETTLE_CYCLES   = 4;     // input register plus state register, and margin
    localparam int unsigned QUIET_LIMIT     = 3000;  // cycles with no transaction anywhere
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned MAX_GAP         = 5;
    localparam int unsigned RANDOM_ITEMS    = 1650;
    localparam int unsigned REPORT_LINES    = 60;

    localparam logic [TIME_BITS_DEF-1:0] TIME_MAX = '1;
    localparam longint unsigned RES_MAX = (64'd1 << RES_W) - 64'd1;

    // input operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // first index past the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_CM_PER_US_Q16 + 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRELOW,
        PH_HIGH,
        PH_WAIT,
        PH_MEASURE
    } t_ranger_phase;

    typedef struct packed {
        t_status          status;
        logic [RES_W-1:0] pulse_us;
        logic [RES_W-1:0] distance_cm;
    } t_range_result;

    // ranging predictor and queue of expected result transactions
    class ranger_scoreboard;
        t_cfg                     cfg;
        t_ranger_phase            phase;
        logic [7:0]               phase_cnt;
        logic [TIME_BITS_DEF-1:0] elapsed_us;
        logic [TIME_BITS_DEF-1:0] echo_width_us;
        logic [RES_W-1:0]         last_pulse_us;
        logic [RES_W-1:0]         last_distance_cm;
        t_range_result            expected_q[$];
        int unsigned              mismatches;

        function new();
            cfg.pre_low_us        = RST_PRE_LOW_US;
            cfg.trigger_us        = RST_TRIGGER_US;
            cfg.timeout_us        = RST_TIMEOUT_US;
            cfg.echo_active_level = RST_ECHO_ACTIVE;
            cfg.cm_per_us_q16     = RST_CM_PER_US_Q16;
            phase            = PH_IDLE;
            phase_cnt        = '0;
            elapsed_us       = '0;
            echo_width_us    = '0;
            last_pulse_us    = '0;
            last_distance_cm = '0;
            mismatches       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PRE_LOW_US:    cfg.pre_low_us        = data[7:0];
                CFG_TRIGGER_US:    cfg.trigger_us        = data[7:0];
                CFG_TIMEOUT_US:    cfg.timeout_us        = data[15:0];
                CFG_ECHO_ACTIVE:   cfg.echo_active_level = data[0];
                CFG_CM_PER_US_Q16: cfg.cm_per_us_q16     = data[15:0];
                default: ;
            endcase
        endfunction

        // saturating microsecond counter
        function logic [TIME_BITS_DEF-1:0] bump(logic [TIME_BITS_DEF-1:0] v);
            return (v == TIME_MAX) ? v : v + 1'b1;
        endfunction

        function void note_input(logic op, logic echo);
            logic            active;
            logic            done;
            logic            tout;
            longint unsigned w64;
            longint unsigned d64;
            t_range_result   r;
            active = (echo == cfg.echo_active_level);
            done   = 1'b0;
            tout   = 1'b0;
            if (op == OP_START) begin
                // ignored while a measurement runs
                if (phase == PH_IDLE) begin
                    phase_cnt     = '0;
                    elapsed_us    = '0;
                    echo_width_us = '0;
                    phase = (cfg.pre_low_us == 8'd0) ? PH_HIGH : PH_PRELOW;
                end
            end else begin
                case (phase)
                    PH_PRELOW: begin
                        phase_cnt = phase_cnt + 8'd1;
                        if (phase_cnt >= cfg.pre_low_us) begin
                            phase     = PH_HIGH;
                            phase_cnt = '0;
                        end
                    end
                    PH_HIGH: begin
                        phase_cnt = phase_cnt + 8'd1;
                        if (phase_cnt >= cfg.trigger_us) begin
                            phase         = PH_WAIT;
                            phase_cnt     = '0;
                            elapsed_us    = '0;
                            echo_width_us = '0;
                        end
                    end
                    PH_WAIT: begin
                        elapsed_us = bump(elapsed_us);
                        if (active) begin
                            phase         = PH_MEASURE;
                            echo_width_us = TIME_BITS_DEF'(1);
                        end else if (elapsed_us >= cfg.timeout_us || elapsed_us == TIME_MAX) begin
                            done = 1'b1;
                            tout = 1'b1;
                        end
                    end
                    PH_MEASURE: begin
                        elapsed_us = bump(elapsed_us);
                        if (!active) begin
                            done = 1'b1;
                        end else begin
                            echo_width_us = bump(echo_width_us);
                            if (elapsed_us >= cfg.timeout_us || elapsed_us == TIME_MAX) begin
                                done = 1'b1;
                                tout = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (done) begin
                    if (tout) begin
                        last_pulse_us    = '0;
                        last_distance_cm = '0;
                    end else begin
                        w64 = echo_width_us;
                        d64 = (w64 * cfg.cm_per_us_q16) >> 16;
                        last_pulse_us    = (w64 > RES_MAX) ? RES_W'(RES_MAX) : RES_W'(w64);
                        last_distance_cm = (d64 > RES_MAX) ? RES_W'(RES_MAX) : RES_W'(d64);
                    end
                    phase     = PH_IDLE;
                    phase_cnt = '0;
                end
            end
            r.status.trigger_level = (phase == PH_HIGH);
            r.status.busy          = (phase != PH_IDLE);
            r.status.done          = done;
            r.status.timed_out     = tout;
            r.pulse_us             = last_pulse_us;
            r.distance_cm          = last_distance_cm;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            if (mismatches < REPORT_LINES)
                $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(t_range_result got);
            t_range_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing expected, pulse %0d", got.pulse_us));
            end else begin
                want = expected_q.pop_front();
                if (got.status.trigger_level !== want.status.trigger_level)
                    report($sformatf("trigger_level got %0b want %0b",
                        got.status.trigger_level, want.status.trigger_level));
                if (got.status.busy !== want.status.busy)
                    report($sformatf("busy got %0b want %0b", got.status.busy, want.status.busy));
                if (got.status.done !== want.status.done)
                    report($sformatf("done got %0b want %0b", got.status.done, want.status.done));
                if (got.status.timed_out !== want.status.timed_out)
                    report($sformatf("timed_out got %0b want %0b",
                        got.status.timed_out, want.status.timed_out));
                if (got.pulse_us !== want.pulse_us)
                    report($sformatf("pulse_us got %0d want %0d", got.pulse_us, want.pulse_us));
                if (got.distance_cm !== want.distance_cm)
                    report($sformatf("distance_cm got %0d want %0d",
                        got.distance_cm, want.distance_cm));
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    uer_in_if  range_in ();
    uer_cfg_if range_cfg ();
    uer_out_if range_out ();

    ranger_scoreboard sb;

    // run control for the sender and the receiver
    bit          no_idle     = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned items_sent  = 0;

    ultrasonic_echo_ranger_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (range_in),
        .i_cfg   (range_cfg),
        .o_out   (range_out)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // offer one input transaction after a random gap (none while no_idle is set), return at the accepting edge;
    // valid stays high so a back-to-back item never lowers and raises it in one step
    task automatic send_item(input logic op, input logic echo);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            range_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        range_in.valid      <= 1'b1;
        range_in.operation  <= op;
        range_in.echo_level <= echo;
        do @(posedge i_clk); while (!(range_in.valid && range_in.ready));
        sb.note_input(op, echo);
        items_sent++;
    endtask

    // lower valid and let every outstanding result drain, then let the pipe settle
    task automatic drain();
        range_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        range_cfg.valid <= 1'b1;
        range_cfg.index <= idx;
        range_cfg.data  <= data;
        do @(posedge i_clk); while (!(range_cfg.valid && range_cfg.ready));
        sb.write_reg(idx, data);
        range_cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // full register set while idle; unused upper data bits carry random junk
    task automatic set_config(input logic [7:0] pre_low, input logic [7:0] trig,
                              input logic [15:0] timeout, input logic active,
                              input logic [15:0] scale);
        drain();
        write_reg(CFG_PRE_LOW_US, {8'($urandom), pre_low});
        write_reg(CFG_TRIGGER_US, {8'($urandom), trig});
        write_reg(CFG_TIMEOUT_US, timeout);
        write_reg(CFG_ECHO_ACTIVE, {15'($urandom), active});
        write_reg(CFG_CM_PER_US_Q16, scale);
        // now and then a write past the register map
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
    endtask

    // one well-formed measurement: start, trigger ticks with junk echo, idle echo, pulse
    task automatic run_ranging(input int unsigned wait_len, input int unsigned width_len);
        int unsigned trig_ticks;
        logic        act;
        act        = sb.cfg.echo_active_level;
        trig_ticks = sb.cfg.pre_low_us + ((sb.cfg.trigger_us == 8'd0) ? 1 : sb.cfg.trigger_us);
        send_item(OP_START, 1'($urandom));
        repeat (trig_ticks) begin
            // stray start while busy
            if ($urandom_range(0, 19) == 0)
                send_item(OP_START, 1'($urandom));
            send_item(OP_TICK, 1'($urandom));
        end
        repeat (wait_len) send_item(OP_TICK, ~act);
        repeat (width_len) send_item(OP_TICK, act);
        send_item(OP_TICK, ~act);
    endtask

    task automatic send_noise(input int unsigned count);
        repeat (count)
            send_item(($urandom_range(0, 3) == 0) ? OP_START : OP_TICK, 1'($urandom));
    endtask

    // stimulus and end of run
    initial begin : stimulus
        int unsigned      phase_no;
        int unsigned      seqs;
        int unsigned      kind;
        logic [7:0]       pre_low;
        logic [7:0]       trig;
        logic [15:0]      timeout;

        range_in.valid      <= 1'b0;
        range_in.operation  <= OP_TICK;
        range_in.echo_level <= 1'b0;
        range_cfg.valid     <= 1'b0;
        range_cfg.index     <= CFG_PRE_LOW_US;
        range_cfg.data      <= '0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: ticks while idle, start while busy, echo ignored in the trigger
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_START, 1'b1);
        send_item(OP_START, 1'b0);
        repeat (RST_PRE_LOW_US + RST_TRIGGER_US) send_item(OP_TICK, 1'b1);
        repeat (2) send_item(OP_TICK, 1'b0);
        repeat (3) send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);

        // zero pre-low, zero trigger, zero timeout, active low echo, full scale
        set_config(8'd0, 8'd0, 16'd0, 1'b0, 16'hFFFF);
        send_item(OP_START, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);     // no echo yet, timeout expires at once
        send_item(OP_START, 1'b1);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);     // echo arrives
        send_item(OP_TICK, 1'b1);     // echo ends before the timeout test

        // longest trigger phases, full timeout, a long pulse at full scale
        no_idle = 1'b1;
        set_config(8'd255, 8'd255, 16'hFFFF, 1'b1, 16'hFFFF);
        run_ranging(3, 300);
        no_idle = 1'b0;

        // random phases of mostly well-formed measurements
        phase_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pre_low = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            trig    = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            kind    = $urandom_range(0, 9);
            if (kind == 0)
                timeout = 16'($urandom);
            else if (kind == 1)
                timeout = 16'($urandom_range(0, 2));
            else
                timeout = 16'($urandom_range(3, 40));
            set_config(pre_low, trig, timeout, 1'($urandom), 16'($urandom));

            no_idle = ($urandom_range(0, 4) == 0);
            // back up the block: receiver holds off while the sender keeps offering
            if (phase_no == 1) begin
                no_idle     = 1'b1;
                rx_hold_req = 1'b1;
            end

            seqs = $urandom_range(3, 8);
            for (int s = 0; s < seqs; s++) begin
                kind = $urandom_range(0, 19);
                if (kind < 3) begin
                    send_noise($urandom_range(1, 8));
                end else if (kind < 5) begin
                    // cut-short measurement, next start may land while busy
                    send_item(OP_START, 1'($urandom));
                    repeat ($urandom_range(1, 6)) send_item(OP_TICK, 1'($urandom));
                end else begin
                    run_ranging(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(0, 8),
                                ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                             : $urandom_range(1, 25));
                end
                // sender pauses until every result is back
                if (phase_no == 2 && s == 1)
                    drain();
            end
            phase_no++;
        end

        drain();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("** ultrasonic_echo_ranger_core: PASSED **");
        else
            $display("** ultrasonic_echo_ranger_core: FAILED **");
        $finish;
    end

    // result receiver with random stalls and one long hold-off
    initial begin : result_sink
        int unsigned   stall;
        t_range_result got;
        range_out.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                stall       = HOLD_OFF_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                range_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            range_out.ready <= 1'b1;
            do @(posedge i_clk); while (!(range_out.valid && range_out.ready));
            got.status.trigger_level = range_out.trigger_level;
            got.status.busy          = range_out.busy_res;
            got.status.done          = range_out.done_res;
            got.status.timed_out     = range_out.timed_out;
            got.pulse_us             = range_out.pulse_us;
            got.distance_cm          = range_out.distance_cm;
            sb.check_result(got);
        end
    end

    // watchdog: too long without any transaction ends the run
    initial begin : quiet_watch
        int unsigned quiet;
        quiet = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((range_in.valid && range_in.ready) || (range_out.valid && range_out.ready)
                || (range_cfg.valid && range_cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** ultrasonic_echo_ranger_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_in_if.sv
rtl/uer_out_if.sv
rtl/uer_cfg_if.sv
rtl/uer_scale.sv
rtl/uer_fsm.sv
rtl/ultrasonic_echo_ranger_core.sv
rtl/uer_chk.sv
tb/sv/ultrasonic_echo_ranger_core_tb.sv
